@@ src/srt_pkg.sv @@
`default_nettype none
package srt_pkg;

   localparam int TRIG_ITERATIONS_DEF = 16;
   localparam int ATAN_LEN = 24;

   // angles in 1/64 degree
   localparam int FULL_TURN = 23040;
   localparam int HALF_TURN = 11520;
   localparam int QUARTER_TURN = 5760;

   localparam int XW = 34;   // cordic x/y, Q2.30 with headroom
   localparam int ZW = 26;   // cordic angle, Q16.16 degrees
   localparam int TW = 18;   // sine/cosine, Q16.16 in [-1, 1]
   localparam int PW = 36;   // product of two sines/cosines
   localparam int RW = 20;   // rotation element, Q16.16

   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [XW-1:0] INV_GAIN = 34'sd652032874;
   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   localparam logic [1:0] ROW_X = 2'd0;
   localparam logic [1:0] ROW_Y = 2'd1;
   localparam logic [1:0] ROW_Z = 2'd2;
   localparam logic [1:0] ROW_LAST = 2'd3;

   typedef logic signed [31:0] word_type;
   typedef logic signed [XW-1:0] xy_type;
   typedef logic signed [ZW-1:0] zang_type;
   typedef logic signed [TW-1:0] trig_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [RW-1:0] rot_type;

   typedef struct packed {
      zang_type z;
      logic     neg;
   } fold_type;

   // lane 0 is x, 1 is y, 2 is z
   typedef struct packed {
      word_type [2:0] scale;
      word_type [2:0] pos;
      zang_type [2:0] z;
      logic [2:0]     neg;
   } item_type;

   // atan(2^-i) in Q16.16 degrees
   function automatic zang_type atan_deg(input logic [4:0] i);
      zang_type r;
      unique case (i)
         5'd0:  r = 26'sd2949120;
         5'd1:  r = 26'sd1740967;
         5'd2:  r = 26'sd919879;
         5'd3:  r = 26'sd466945;
         5'd4:  r = 26'sd234379;
         5'd5:  r = 26'sd117304;
         5'd6:  r = 26'sd58666;
         5'd7:  r = 26'sd29335;
         5'd8:  r = 26'sd14668;
         5'd9:  r = 26'sd7334;
         5'd10: r = 26'sd3667;
         5'd11: r = 26'sd1833;
         5'd12: r = 26'sd917;
         5'd13: r = 26'sd458;
         5'd14: r = 26'sd229;
         5'd15: r = 26'sd115;
         5'd16: r = 26'sd57;
         5'd17: r = 26'sd29;
         5'd18: r = 26'sd14;
         5'd19: r = 26'sd7;
         5'd20: r = 26'sd4;
         5'd21: r = 26'sd2;
         5'd22: r = 26'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/srt_if.sv @@
`default_nettype none
interface srt_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] scale_x;
   logic signed [31:0] scale_y;
   logic signed [31:0] scale_z;
   logic signed [15:0] angle_x;
   logic signed [15:0] angle_y;
   logic signed [15:0] angle_z;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;

   modport source (output valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                   pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                 pos_x, pos_y, pos_z, output ready);
endinterface

interface srt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  row_index;
   logic signed [31:0] col_one;
   logic signed [31:0] col_two;
   logic signed [31:0] col_three;
   logic signed [31:0] col_four;
   logic        last_row;

   modport source (output valid, row_index, col_one, col_two, col_three, col_four,
                   last_row, input ready);
   modport sink (input valid, row_index, col_one, col_two, col_three, col_four,
                 last_row, output ready);
endinterface
`default_nettype wire

@@ src/srt_front.sv @@
`default_nettype none
module srt_front (
   srt_req_if.sink          req_ch,
   input  logic             q_full,
   output logic             q_push,
   output srt_pkg::item_type q_item
);
   import srt_pkg::*;

   // reduce to [-180,180) then fold into [-90,90]
   function automatic fold_type fold_angle(input logic signed [15:0] a);
      logic signed [16:0] r;
      fold_type f;
      r = 17'(a);
      f.neg = 1'b0;
      if (r >= HALF_TURN) begin
         r = r - 17'(FULL_TURN);
      end else if (r < -HALF_TURN) begin
         r = r + 17'(FULL_TURN);
      end
      if (r > QUARTER_TURN) begin
         r = r - 17'(HALF_TURN);
         f.neg = 1'b1;
      end else if (r < -QUARTER_TURN) begin
         r = r + 17'(HALF_TURN);
         f.neg = 1'b1;
      end
      f.z = zang_type'(r) <<< 10;
      return f;
   endfunction

   fold_type fx, fy, fz;

   always_comb begin
      fx = fold_angle(req_ch.angle_x);
      fy = fold_angle(req_ch.angle_y);
      fz = fold_angle(req_ch.angle_z);
      q_item.scale = {req_ch.scale_z, req_ch.scale_y, req_ch.scale_x};
      q_item.pos = {req_ch.pos_z, req_ch.pos_y, req_ch.pos_x};
      q_item.z = {fz.z, fy.z, fx.z};
      q_item.neg = {fz.neg, fy.neg, fx.neg};
   end

   assign req_ch.ready = !q_full;
   assign q_push = req_ch.valid && !q_full;

endmodule
`default_nettype wire

@@ src/srt_queue.sv @@
`default_nettype none
module srt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srt_pkg::item_type push_item,
   output logic              full,
   output logic              q_valid,
   output srt_pkg::item_type q_item,
   input  logic              pop
);
   import srt_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type       slot_ff [DEPTH];
   logic [AW-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]  count_ff, count_in;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

   assign full = (count_ff == CW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item = slot_ff[rptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule
`default_nettype wire

@@ src/srt_back.sv @@
`default_nettype none
module srt_back #(
   parameter int ITERS = srt_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  srt_pkg::item_type q_item,
   output logic              pop,
   srt_rsp_if.source         rsp_ch
);
   import srt_pkg::*;

   localparam int NST = ITERS + 5;
   localparam int S_TRIG = ITERS + 1;
   localparam int S_M1 = ITERS + 2;
   localparam int S_M2 = ITERS + 3;
   localparam int S_MAT = ITERS + 4;

   typedef struct packed {
      word_type [2:0] scale;
      word_type [2:0] pos;
      logic [2:0]     neg;
      xy_type [2:0]   x;
      xy_type [2:0]   y;
      zang_type [2:0] z;
   } cstage_type;

   typedef struct packed {
      word_type [2:0] scale;
      word_type [2:0] pos;
      trig_type [2:0] s;
      trig_type [2:0] c;
   } tstage_type;

   typedef struct packed {
      word_type [2:0] scale;
      word_type [2:0] pos;
      trig_type sz, cz, sy;
      prod_type cz_cy, sz_cy, cy_sx, cy_cx, sy_sx, sy_cx, sz_cx, cz_cx, sz_sx, cz_sx;
   } pstage_type;

   typedef struct packed {
      word_type [2:0] scale;
      word_type [2:0] pos;
      rot_type [8:0]  r;
   } rstage_type;

   typedef struct packed {
      word_type [2:0] pos;
      word_type [8:0] m;
   } mat_type;

   function automatic trig_type to_q16(input xy_type v, input logic neg);
      logic signed [XW:0] t;
      logic signed [XW-14:0] q;
      trig_type r;
      t = (XW + 1)'(v) + (XW + 1)'(8192);
      q = t[XW:14];
      if (q > 65536) begin
         r = TW'(65536);
      end else if (q < -65536) begin
         r = -TW'(65536);
      end else begin
         r = TW'(q);
      end
      if (neg) begin
         r = -r;
      end
      return r;
   endfunction

   // Q16.48 to Q16.16, round half up
   function automatic rot_type rnd48(input logic signed [55:0] v);
      logic signed [55:0] t;
      t = v + (56'sd1 <<< 31);
      return rot_type'(t >>> 32);
   endfunction

   function automatic word_type scale_mul(input word_type s, input rot_type e);
      logic signed [51:0] p;
      logic signed [52:0] t;
      logic signed [36:0] q;
      word_type r;
      p = s * e;
      t = 53'(p) + 53'sd32768;
      q = t[52:16];
      if (q > 37'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (q < -37'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = word_type'(q);
      end
      return r;
   endfunction

   logic [NST-1:0] v_ff;
   logic           adv, take, fire;
   cstage_type     cs_ff [0:ITERS];
   cstage_type     cs_start_in;
   tstage_type     ts_ff, ts_in;
   pstage_type     ps_ff, ps_in;
   rstage_type     rs_ff, rs_in;
   mat_type        mat_ff, mat_in;
   mat_type        out_ff;
   logic           busy_ff, busy_in;
   logic [1:0]     row_ff, row_in;

   assign fire = rsp_ch.valid && rsp_ch.ready;
   assign take = !busy_ff || (fire && row_ff == ROW_LAST);
   assign adv = !v_ff[S_MAT] || take;
   assign pop = adv && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], q_valid};
      end
   end

   always_comb begin
      cs_start_in.scale = q_item.scale;
      cs_start_in.pos = q_item.pos;
      cs_start_in.neg = q_item.neg;
      cs_start_in.x = {3{INV_GAIN}};
      cs_start_in.y = '0;
      cs_start_in.z = q_item.z;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cs_ff[0] <= cs_start_in;
      end
   end

   // one cordic iteration per stage, three angles side by side
   for (genvar j = 0; j < ITERS; j++) begin : g_iter
      cstage_type step_in;
      always_comb begin
         step_in = cs_ff[j];
         for (int l = 0; l < 3; l++) begin
            if (!cs_ff[j].z[l][ZW-1]) begin
               step_in.x[l] = cs_ff[j].x[l] - (cs_ff[j].y[l] >>> j);
               step_in.y[l] = cs_ff[j].y[l] + (cs_ff[j].x[l] >>> j);
               step_in.z[l] = cs_ff[j].z[l] - atan_deg(5'(j));
            end else begin
               step_in.x[l] = cs_ff[j].x[l] + (cs_ff[j].y[l] >>> j);
               step_in.y[l] = cs_ff[j].y[l] - (cs_ff[j].x[l] >>> j);
               step_in.z[l] = cs_ff[j].z[l] + atan_deg(5'(j));
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cs_ff[j+1] <= step_in;
         end
      end
   end

   always_comb begin
      ts_in.scale = cs_ff[ITERS].scale;
      ts_in.pos = cs_ff[ITERS].pos;
      for (int l = 0; l < 3; l++) begin
         ts_in.c[l] = to_q16(cs_ff[ITERS].x[l], cs_ff[ITERS].neg[l]);
         ts_in.s[l] = to_q16(cs_ff[ITERS].y[l], cs_ff[ITERS].neg[l]);
      end
   end

   always_comb begin
      ps_in.scale = ts_ff.scale;
      ps_in.pos = ts_ff.pos;
      ps_in.sz = ts_ff.s[2];
      ps_in.cz = ts_ff.c[2];
      ps_in.sy = ts_ff.s[1];
      ps_in.cz_cy = ts_ff.c[2] * ts_ff.c[1];
      ps_in.sz_cy = ts_ff.s[2] * ts_ff.c[1];
      ps_in.cy_sx = ts_ff.c[1] * ts_ff.s[0];
      ps_in.cy_cx = ts_ff.c[1] * ts_ff.c[0];
      ps_in.sy_sx = ts_ff.s[1] * ts_ff.s[0];
      ps_in.sy_cx = ts_ff.s[1] * ts_ff.c[0];
      ps_in.sz_cx = ts_ff.s[2] * ts_ff.c[0];
      ps_in.cz_cx = ts_ff.c[2] * ts_ff.c[0];
      ps_in.sz_sx = ts_ff.s[2] * ts_ff.s[0];
      ps_in.cz_sx = ts_ff.c[2] * ts_ff.s[0];
   end

   logic signed [53:0] t_cz_sysx, t_cz_sycx, t_sz_sysx, t_sz_sycx;
   rot_type            neg_sy;

   always_comb begin
      t_cz_sysx = ps_ff.cz * ps_ff.sy_sx;
      t_cz_sycx = ps_ff.cz * ps_ff.sy_cx;
      t_sz_sysx = ps_ff.sz * ps_ff.sy_sx;
      t_sz_sycx = ps_ff.sz * ps_ff.sy_cx;
      neg_sy = rot_type'(ps_ff.sy);
      rs_in.scale = ps_ff.scale;
      rs_in.pos = ps_ff.pos;
      rs_in.r[0] = rnd48(56'(ps_ff.cz_cy) <<< 16);
      rs_in.r[1] = rnd48(56'(t_cz_sysx) - (56'(ps_ff.sz_cx) <<< 16));
      rs_in.r[2] = rnd48(56'(t_cz_sycx) + (56'(ps_ff.sz_sx) <<< 16));
      rs_in.r[3] = rnd48(56'(ps_ff.sz_cy) <<< 16);
      rs_in.r[4] = rnd48(56'(t_sz_sysx) + (56'(ps_ff.cz_cx) <<< 16));
      rs_in.r[5] = rnd48(56'(t_sz_sycx) - (56'(ps_ff.cz_sx) <<< 16));
      rs_in.r[6] = -neg_sy;
      rs_in.r[7] = rnd48(56'(ps_ff.cy_sx) <<< 16);
      rs_in.r[8] = rnd48(56'(ps_ff.cy_cx) <<< 16);
   end

   always_comb begin
      mat_in.pos = rs_ff.pos;
      for (int e = 0; e < 9; e++) begin
         mat_in.m[e] = scale_mul(rs_ff.scale[e / 3], rs_ff.r[e]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ts_ff <= ts_in;
         ps_ff <= ps_in;
         rs_ff <= rs_in;
         mat_ff <= mat_in;
      end
   end

   // row emitter: holds one finished matrix and sends it a row per request
   always_comb begin
      busy_in = busy_ff;
      row_in = row_ff;
      if (take && v_ff[S_MAT]) begin
         busy_in = 1'b1;
         row_in = ROW_X;
      end else if (fire) begin
         row_in = row_ff + 1'b1;
         if (row_ff == ROW_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff <= ROW_X;
      end else begin
         busy_ff <= busy_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && v_ff[S_MAT]) begin
         out_ff <= mat_ff;
      end
   end

   always_comb begin
      rsp_ch.valid = busy_ff;
      rsp_ch.row_index = row_ff;
      rsp_ch.last_row = (row_ff == ROW_LAST);
      rsp_ch.col_four = '0;
      case (row_ff)
         ROW_X: begin
            rsp_ch.col_one = out_ff.m[0];
            rsp_ch.col_two = out_ff.m[1];
            rsp_ch.col_three = out_ff.m[2];
         end
         ROW_Y: begin
            rsp_ch.col_one = out_ff.m[3];
            rsp_ch.col_two = out_ff.m[4];
            rsp_ch.col_three = out_ff.m[5];
         end
         ROW_Z: begin
            rsp_ch.col_one = out_ff.m[6];
            rsp_ch.col_two = out_ff.m[7];
            rsp_ch.col_three = out_ff.m[8];
         end
         default: begin
            rsp_ch.col_one = out_ff.pos[0];
            rsp_ch.col_two = out_ff.pos[1];
            rsp_ch.col_three = out_ff.pos[2];
            rsp_ch.col_four = ONE_Q16;
         end
      endcase
   end

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty queue");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (fire && row_ff != ROW_LAST) |=> (busy_ff && row_ff == $past(row_ff) + 1'b1))
      else $error("row sequence broken");

   a_mat_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[S_MAT] && !take) |=> v_ff[S_MAT])
      else $error("finished matrix dropped while emitter busy");

endmodule
`default_nettype wire

@@ src/srt_matrix_from_euler.sv @@
`default_nettype none
// World matrix builder: each request (scale, three Euler angles in 1/64 degree, position)
// yields four result rows in order, rows 0-2 the scaled Rz*Ry*Rx rotation rows with
// column four zero, row 3 the position with 1.0 and last_row set, all Q16.16 saturated.
// A request is taken in the cycle it is offered while the two-entry queue has room; its
// first row is offered after the queue slot, the CORDIC stages and the trig, product,
// rotation, matrix and output registers. The emitter's four rows per request bound the
// sustained rate; the sine/cosine pipeline (a CORDIC stage per iteration, all three angles)
// and product stages take a new request every cycle unless the busy emitter stalls them.
module srt_matrix_from_euler #(
   parameter int TRIG_ITERATIONS = srt_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   srt_req_if.sink   req_ch,
   srt_rsp_if.source rsp_ch
);
   import srt_pkg::*;

   logic     q_full, q_push, q_valid, q_pop;
   item_type push_item, q_item;

   srt_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (push_item)
   );

   srt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (q_pop)
   );

   srt_back #(
      .ITERS (TRIG_ITERATIONS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .pop     (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire
